// File: rtl/mavg_pkg.sv
`default_nettype none

package mavg_pkg;

    // Field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned AVG_W    = 20;
    localparam int unsigned WIN_W    = 4;
    localparam int unsigned FRAC_W   = 4;

    // Largest window the 4-bit register can name
    localparam int unsigned WIN_FIELD_MAX = 15;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    // Control strobes into the sample store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } store_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mavg_store.sv
`default_nettype none

module mavg_store import mavg_pkg::*; #(
    parameter int unsigned DEPTH  = 9,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire store_ctrl_t                ctrl,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic signed [SAMPLE_W-1:0] wr_data,
    output logic signed [SAMPLE_W-1:0]      rd_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [DEPTH-1:0]           valid_next;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    // Track written entries; clear drops all of them at once
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: rtl/mavg_div.sv
`default_nettype none

module mavg_div import mavg_pkg::*; #(
    parameter int unsigned DVD_W = 24
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [WIN_W-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [WIN_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIN_W:0]   shifted;
    logic [WIN_W:0]   diff;
    logic             ge;

    // One restoring step per cycle, quotient bits shift in at the bottom
    always_comb begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/moving_average_filter.sv
// Each beat is read from the store, folded into the sum and written back, then divided by
// the bit-serial divider, one quotient bit per cycle, and placed in the output register;
// the store is read and written once, and no new beat is taken until the last is done.
// A new beat is taken while a finished result still waits in the output register.
// Reset (aresetn, synchronous, active low): window 3, sum and position zero, all stored
// samples read as zero; a window write clears the sum, position and stored samples.
`default_nettype none

module moving_average_filter import mavg_pkg::*; #(
    parameter int unsigned MAX_WINDOW = 9
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [WIN_W-1:0]           cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [AVG_W-1:0]         m_average
);

    localparam int unsigned POS_W = $clog2(MAX_WINDOW);
    localparam int unsigned SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int unsigned DVD_W = SUM_W + FRAC_W;
    localparam int unsigned CMP_W = POS_W + WIN_W;
    localparam int unsigned WCAP  = (MAX_WINDOW > WIN_FIELD_MAX) ? WIN_FIELD_MAX : MAX_WINDOW;
    localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WCAP);

    state_t                     state_reg, state_next;
    logic [WIN_W-1:0]           window_size_reg, window_size_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       neg_reg, neg_next;
    logic signed [AVG_W-1:0]    avg_reg, avg_next;
    logic                       m_valid_reg, m_valid_next;

    logic [WIN_W-1:0]           eff_window;
    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           pos_inc_ext;
    logic [CMP_W-1:0]           win_ext;
    logic [POS_W-1:0]           rd_pos;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]           sum_mag;
    logic [AVG_W-1:0]           quo_trunc;

    store_ctrl_t                store_ctrl;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [DVD_W-1:0]           div_quotient;

    // Window in effect: zero acts as one, clip to the store depth
    always_comb begin
        if (window_size_reg == '0) begin
            eff_window = WIN_W'(1);
        end else if (window_size_reg > WIN_CAP) begin
            eff_window = WIN_CAP;
        end else begin
            eff_window = window_size_reg;
        end
        pos_ext     = CMP_W'(pos_reg);
        pos_inc_ext = pos_ext + CMP_W'(1);
        win_ext     = CMP_W'(eff_window);
        rd_pos      = (pos_ext >= win_ext) ? '0 : pos_reg;
        sum_mag     = sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
        quo_trunc   = div_quotient[AVG_W-1:0];
    end

    mavg_store #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (POS_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (store_ctrl),
        .rd_addr (rd_pos),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_data (old_sample)
    );

    mavg_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sum_mag, FRAC_W'(0)}),
        .divisor  (eff_window),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer: read old sample, update sum and store, divide, hand off
    always_comb begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        pos_next         = pos_reg;
        sample_next      = sample_reg;
        sum_next         = sum_reg;
        neg_next         = neg_reg;
        avg_next         = avg_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        store_ctrl       = '0;
        div_start        = 1'b0;
        s_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sample_next      = s_sample;
                    pos_next         = rd_pos;
                    store_ctrl.rd_en = 1'b1;
                    state_next       = ST_READ;
                end
            end
            ST_READ: begin
                sum_next = sum_reg
                           - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample}
                           + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
                store_ctrl.wr_en = 1'b1;
                pos_next   = (pos_inc_ext == win_ext) ? '0 : pos_inc_ext[POS_W-1:0];
                state_next = ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    avg_next     = neg_reg ? (AVG_W'(0) - quo_trunc) : quo_trunc;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // Window write clears the history
        if (cfg_wr_en) begin
            window_size_next = cfg_wr_data;
            sum_next         = '0;
            pos_next         = '0;
            store_ctrl.clear = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_RESET;
            pos_reg         <= '0;
            sum_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        neg_reg    <= neg_next;
        avg_reg    <= avg_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_average = avg_reg;

`ifndef SYNTHESIS
    // Write position stays inside the window while waiting for a beat
    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> pos_ext < win_ext)
        else $error("write position outside window");

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // No new beat while a division is in flight
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> !s_ready)
        else $error("input ready while divider busy");

    // Store read and write never share a cycle
    a_store_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(store_ctrl.rd_en && store_ctrl.wr_en))
        else $error("store read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// File: verif/tb_moving_average_filter.sv
`default_nettype none

module tb_moving_average_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int WIN_DEPTH    = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 40;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [WIN_W-1:0]           cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready = 1'b1;
    logic signed [AVG_W-1:0]    m_average;

    // Shadow copy of the filter state
    logic [WIN_W-1:0]           win_reg;
    logic signed [SAMPLE_W-1:0] hist [WIN_DEPTH];
    longint                     hist_sum;
    int                         hist_pos;

    // Averages still owed by the block, oldest first
    logic signed [AVG_W-1:0]    pending_averages [$];

    int  mismatch_count;
    int  cycle_count;
    bit  idle_mode;
    int  stall_left;

    moving_average_filter #(
        .MAX_WINDOW (WIN_DEPTH)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Empty the sample history
    function automatic void clear_history();
        for (int k = 0; k < WIN_DEPTH; k++) begin
            hist[k] = '0;
        end
        hist_sum = 0;
        hist_pos = 0;
    endfunction

    // Fold one sample into the window and return the scaled mean
    function automatic logic signed [AVG_W-1:0] predict_average(
        input logic signed [SAMPLE_W-1:0] smp
    );
        int     eff;
        longint scaled;
        eff = int'(win_reg);
        if (eff == 0) begin
            eff = 1;
        end
        if (eff > WIN_DEPTH) begin
            eff = WIN_DEPTH;
        end
        if (hist_pos >= eff) begin
            hist_pos = 0;
        end
        hist_sum = hist_sum - longint'(hist[hist_pos]) + longint'(smp);
        hist[hist_pos] = smp;
        hist_pos = (hist_pos + 1) % eff;
        // signed division truncates toward zero
        scaled = (hist_sum * (1 << FRAC_W)) / eff;
        return scaled[AVG_W-1:0];
    endfunction

    // Mix of rail values, near-zero readings and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        int                         t;
        case ($urandom_range(0, 9))
            0: begin
                v = 16'sh8000;
            end
            1: begin
                v = 16'sh7fff;
            end
            2, 3, 4: begin
                t = $urandom_range(0, 400);
                v = SAMPLE_W'(t - 200);
            end
            default: begin
                v = SAMPLE_W'($urandom_range(0, 65535));
            end
        endcase
        return v;
    endfunction

    // Present one beat, hold it until taken, then log its expected average
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        if (idle_mode && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = smp;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_averages.push_back(predict_average(smp));
        @(negedge aclk);
    endtask

    // Drop valid and let every owed average drain out
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_averages.size() != 0) @(negedge aclk);
    endtask

    // Program the window while the block is quiet
    task automatic write_window(input logic [WIN_W-1:0] w);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = w;
        win_reg     = w;
        clear_history();
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (idle_mode && $urandom_range(0, 5) == 0) begin
            m_ready    = 1'b0;
            stall_left = $urandom_range(0, 13);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge aclk) begin : check_results
        logic signed [AVG_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_averages.size() == 0) begin
                report_mismatch($sformatf("unexpected average %0d", m_average));
            end else begin
                want = pending_averages.pop_front();
                if (m_average !== want) begin
                    report_mismatch($sformatf("average %0d, want %0d", m_average, want));
                end
            end
        end
    end

    // Reset window of 3: partial fill, then both rails and a small value
    task automatic test_default_window();
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(-16'sd1);
    endtask

    // Zero window acts as one; oversized window acts as the maximum
    task automatic test_window_limits();
        write_window(4'd0);
        push_sample(16'sh8000);
        push_sample(16'sh7fff);
        write_window(4'd15);
        // fill the whole window at each rail
        repeat (WIN_DEPTH) push_sample(16'sh7fff);
        repeat (WIN_DEPTH) push_sample(16'sh8000);
    endtask

    // Random samples over a sequence of window settings
    task automatic test_random_windows();
        logic [WIN_W-1:0] w;
        for (int phase = 0; phase < 13; phase++) begin
            case (phase)
                0:       w = 4'd1;
                1:       w = 4'd9;
                2:       w = 4'd10;
                3:       w = 4'd14;
                4:       w = 4'd0;
                5:       w = 4'd2;
                default: w = WIN_W'($urandom_range(0, 15));
            endcase
            write_window(w);
            idle_mode = ($urandom_range(0, 4) != 0);
            repeat (60) push_sample(pick_sample());
        end
    endtask

    // Full-rate streaming with no stalls on either side
    task automatic test_back_to_back();
        write_window(4'd9);
        idle_mode = 1'b0;
        repeat (100) push_sample(pick_sample());
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_sample       = '0;
        idle_mode      = 1'b1;
        stall_left     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        win_reg        = WINDOW_RESET;
        clear_history();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_default_window();
        test_window_limits();
        test_random_windows();
        test_back_to_back();

        // Drain, then watch for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/mavg_pkg.sv
rtl/mavg_store.sv
rtl/mavg_div.sv
rtl/moving_average_filter.sv
verif/tb_moving_average_filter.sv
